// ===== hw/rtl/ash_pkg.sv =====
package ash_pkg;

    // Width of stream offsets and of the byte counter
    localparam int OFFSET_WIDTH = 32;

    typedef logic [OFFSET_WIDTH-1:0] t_off;

    localparam t_off SKIP_LAST        = t_off'(8'h19);
    localparam int   MAP_RECORD       = 12;
    localparam int   MAP_POS_W        = $clog2(MAP_RECORD);
    localparam int   TC_LEN           = 8;
    localparam t_off TC_LEN_OFF       = t_off'(TC_LEN);
    localparam t_off OFF_MAX          = {OFFSET_WIDTH{1'b1}};

    typedef logic [MAP_POS_W-1:0] t_map_pos;

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_NAME = 2'd1;
    localparam logic [1:0] KIND_TC   = 2'd2;
    localparam logic [1:0] KIND_HDR  = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic [7:0] index;
        logic       name_last;
        logic       chunk_end;
    } t_result;

    // Fit a 32-bit map word into the offset width (truncate or zero-extend)
    function automatic t_off to_off(input logic [31:0] word);
        logic [OFFSET_WIDTH+31:0] ext;
        ext = {{OFFSET_WIDTH{1'b0}}, word};
        return ext[OFFSET_WIDTH-1:0];
    endfunction

    localparam t_off NAME_START_RESET = to_off(32'h7FFF_FFFF);

endpackage

// ===== hw/rtl/applesingle_header_stripper.sv =====
// AppleSingle header stripper.
// Input channel: i_in_valid / o_in_stall carry one item per stream byte
// (i_data_byte, i_chunk_last) or a restart item (i_req_type = 1). An item is
// taken at a rising edge with i_in_valid high and o_in_stall low.
// Output channel: o_out_valid / i_out_stall carry one result per stream
// byte: o_out_kind (0 file data, 1 name byte, 2 type/creator byte, 3 header
// byte consumed), o_out_byte, o_out_index, o_name_last, o_chunk_end.
// A restart item yields no result; it returns all header state to reset.
// Path: a stream byte is held in the input register, parsed there and
// its result loaded into the output register, i.e. two register stages deep.
// Throughput: one item per cycle unless the receiver stalls; the input
// register and the output register decouple the sides, and the parser
// updates its counters and offsets in the same cycle it classifies a byte.
// When the receiver stalls, the output register holds its result, the
// parse stage waits and the input register fills, then o_in_stall rises.
// A restart item still drains while the output is stalled.
// Reset (i_rst_n low, synchronous) empties both registers and puts the
// parser back in its start state: byte count 0, no entry map seen.
module applesingle_header_stripper (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_req_type,
    input  logic [7:0] i_data_byte,
    input  logic       i_chunk_last,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_out_kind,
    output logic [7:0] o_out_byte,
    output logic [7:0] o_out_index,
    output logic       o_name_last,
    output logic       o_chunk_end
);
    import ash_pkg::*;

    logic       r_in_valid;
    logic       r_in_req_type;
    logic [7:0] r_in_data_byte;
    logic       r_in_chunk_last;

    logic       out_ready;
    logic       fire;
    logic       in_ready;
    logic       in_accept;
    t_result    core_res;
    t_result    out_res;

    // Advance the held item: a restart needs no output room
    assign fire      = r_in_valid && (r_in_req_type || out_ready);
    assign in_ready  = !r_in_valid || fire;
    assign in_accept = i_in_valid && in_ready;
    assign o_in_stall = !in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    // Capture the item payload only when a new item comes in
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_req_type   <= i_req_type;
            r_in_data_byte  <= i_data_byte;
            r_in_chunk_last <= i_chunk_last;
        end
    end

    ash_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_restart    (r_in_req_type),
        .i_data_byte  (r_in_data_byte),
        .i_chunk_last (r_in_chunk_last),
        .o_res        (core_res)
    );

    ash_outreg u_outreg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (fire && !r_in_req_type),
        .i_res   (core_res),
        .i_stall (i_out_stall),
        .o_ready (out_ready),
        .o_valid (o_out_valid),
        .o_res   (out_res)
    );

    assign o_out_kind  = out_res.kind;
    assign o_out_byte  = out_res.data_byte;
    assign o_out_index = out_res.index;
    assign o_name_last = out_res.name_last;
    assign o_chunk_end = out_res.chunk_end;

    a_fire_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |-> r_in_valid)
        else $error("parse stage fired without an item");

    a_stall_holds_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !fire |=> r_in_valid && $stable(r_in_data_byte)
                                && $stable(r_in_req_type))
        else $error("waiting item lost in input register");

    a_byte_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && !r_in_req_type |=> o_out_valid && o_out_byte == $past(r_in_data_byte))
        else $error("stream byte did not reach the output");

endmodule

// ===== hw/rtl/ash_core.sv =====
module ash_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic             i_restart,
    input  logic [7:0]       i_data_byte,
    input  logic             i_chunk_last,
    output ash_pkg::t_result o_res
);
    import ash_pkg::*;

    localparam t_map_pos POS_ID   = t_map_pos'(3);
    localparam t_map_pos POS_OFF  = t_map_pos'(7);
    localparam t_map_pos POS_LEN  = t_map_pos'(11);
    localparam t_map_pos POS_LAST = t_map_pos'(MAP_RECORD - 1);

    localparam logic [31:0] ID_DATA = 32'd1;
    localparam logic [31:0] ID_NAME = 32'd3;
    localparam logic [31:0] ID_TC   = 32'd9;

    t_off        r_byte_count, n_byte_count;
    t_off        r_name_start, n_name_start;
    t_off        r_name_stop,  n_name_stop;
    t_off        r_tc_start,   n_tc_start;
    t_off        r_data_start, n_data_start;
    logic [31:0] r_entry_id,   n_entry_id;
    logic [31:0] r_word,       n_word;
    t_map_pos    r_map_pos,    n_map_pos;
    logic        r_done,       n_done;

    logic [31:0] word;
    t_off        name_diff;
    t_off        tc_diff;
    logic [1:0]  kind;
    logic [7:0]  index;
    logic        last;

    always_comb begin
        n_byte_count = r_byte_count;
        n_name_start = r_name_start;
        n_name_stop  = r_name_stop;
        n_tc_start   = r_tc_start;
        n_data_start = r_data_start;
        n_entry_id   = r_entry_id;
        n_word       = r_word;
        n_map_pos    = r_map_pos;
        n_done       = r_done;
        kind         = KIND_HDR;
        index        = 8'd0;
        last         = 1'b0;
        name_diff    = r_byte_count - r_name_start;
        tc_diff      = r_byte_count - r_tc_start;

        case (r_map_pos[1:0])
            2'd0:    word = {i_data_byte, 24'd0};
            2'd1:    word = r_word | {8'd0, i_data_byte, 16'd0};
            2'd2:    word = r_word | {16'd0, i_data_byte, 8'd0};
            default: word = r_word | {24'd0, i_data_byte};
        endcase

        if (r_done) begin
            kind = KIND_DATA;
        end else begin
            if (r_byte_count <= SKIP_LAST) begin
                kind = KIND_HDR;
            end else if (r_byte_count < r_name_start) begin
                // entry map: id, offset, length words of 12-byte records
                n_word    = word;
                n_map_pos = (r_map_pos == POS_LAST) ? '0 : r_map_pos + t_map_pos'(1);
                if (r_map_pos == POS_ID) begin
                    n_entry_id = word;
                end else if (r_map_pos == POS_OFF) begin
                    if (r_entry_id == ID_DATA) begin
                        n_data_start = to_off(word);
                    end else if (r_entry_id == ID_NAME) begin
                        n_name_start = to_off(word);
                    end else if (r_entry_id == ID_TC) begin
                        n_tc_start = to_off(word);
                    end
                end else if (r_map_pos == POS_LEN) begin
                    if (r_entry_id == ID_NAME) begin
                        n_name_stop = r_name_start + to_off(word);
                    end
                end
            end else if (r_byte_count < r_name_stop) begin
                kind  = KIND_NAME;
                index = (|name_diff[OFFSET_WIDTH-1:8]) ? 8'hFF : name_diff[7:0];
                last  = (r_byte_count == r_name_stop - t_off'(1));
            end else if (r_byte_count >= r_tc_start && tc_diff < TC_LEN_OFF) begin
                kind  = KIND_TC;
                index = {5'd0, tc_diff[2:0]};
            end else if (r_byte_count == r_data_start) begin
                kind   = KIND_DATA;
                n_done = 1'b1;
            end
            if (!n_done && r_byte_count != OFF_MAX) begin
                n_byte_count = r_byte_count + t_off'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
            r_name_start <= NAME_START_RESET;
            r_name_stop  <= '0;
            r_tc_start   <= '0;
            r_data_start <= '0;
            r_entry_id   <= '0;
            r_word       <= '0;
            r_map_pos    <= '0;
            r_done       <= 1'b0;
        end else if (i_fire) begin
            if (i_restart) begin
                r_byte_count <= '0;
                r_name_start <= NAME_START_RESET;
                r_name_stop  <= '0;
                r_tc_start   <= '0;
                r_data_start <= '0;
                r_entry_id   <= '0;
                r_word       <= '0;
                r_map_pos    <= '0;
                r_done       <= 1'b0;
            end else begin
                r_byte_count <= n_byte_count;
                r_name_start <= n_name_start;
                r_name_stop  <= n_name_stop;
                r_tc_start   <= n_tc_start;
                r_data_start <= n_data_start;
                r_entry_id   <= n_entry_id;
                r_word       <= n_word;
                r_map_pos    <= n_map_pos;
                r_done       <= n_done;
            end
        end
    end

    assign o_res.kind      = kind;
    assign o_res.data_byte = i_data_byte;
    assign o_res.index     = index;
    assign o_res.name_last = last;
    assign o_res.chunk_end = i_chunk_last;

    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done && !(i_fire && i_restart) |=> r_done)
        else $error("header done flag dropped without restart");

    a_map_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_map_pos <= POS_LAST)
        else $error("entry map position out of record");

    a_done_is_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> kind == KIND_DATA && index == 8'd0)
        else $error("byte after header not passed as file data");

    a_last_in_name: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        last |-> kind == KIND_NAME)
        else $error("name last mark outside name");

    a_count_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done && !(i_fire && i_restart) |=> $stable(r_byte_count))
        else $error("byte count moved after header");

endmodule

// ===== hw/rtl/ash_outreg.sv =====
module ash_outreg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  ash_pkg::t_result i_res,
    input  logic             i_stall,
    output logic             o_ready,
    output logic             o_valid,
    output ash_pkg::t_result o_res
);
    import ash_pkg::*;

    logic    r_valid;
    t_result r_res;

    // Take a new result when empty or when the current one leaves
    assign o_ready = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_ready) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

    a_load_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_ready)
        else $error("result loaded into full output register");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |=> r_valid && r_res == $past(i_res))
        else $error("loaded result not presented");

    a_held_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && i_stall |=> r_valid && $stable(r_res))
        else $error("stalled result lost");

endmodule
